// ===== rtl/nsup_pkg.sv =====
// Shared types and constants of the 3x3 neighbor suppression block.
// No dependencies.
`default_nettype none

package nsup_pkg;

    localparam int PIX_W    = 8;
    localparam int CFG_W_W  = 11;
    localparam int CFG_H_W  = 13;
    localparam int ROW_W    = 14;
    localparam int REG_IDX_W = 4;
    localparam int REG_DAT_W = 13;

    localparam logic [REG_IDX_W-1:0] REG_FRAME_WIDTH  = REG_IDX_W'(0);
    localparam logic [REG_IDX_W-1:0] REG_FRAME_HEIGHT = REG_IDX_W'(1);

    localparam logic [CFG_W_W-1:0] RST_FRAME_WIDTH  = CFG_W_W'(48);
    localparam logic [CFG_H_W-1:0] RST_FRAME_HEIGHT = CFG_H_W'(48);

    typedef enum logic {
        OP_PIXEL = 1'b0,
        OP_DRAIN = 1'b1
    } t_opcode;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_out;
        logic             frame_done;
    } t_out_word;

endpackage

`default_nettype wire

// ===== rtl/nsup_if.sv =====
// Valid/ready channel interfaces: pixel input, pixel output, register writes.
// Depends on nsup_pkg.
`default_nettype none

interface nsup_in_if;
    logic                       valid;
    logic                       ready;
    logic                       opcode;
    logic [nsup_pkg::PIX_W-1:0] pixel_in;

    modport source (output valid, output opcode, output pixel_in, input ready);
    modport sink   (input valid, input opcode, input pixel_in, output ready);
endinterface

interface nsup_out_if;
    logic                       valid;
    logic                       ready;
    logic [nsup_pkg::PIX_W-1:0] pixel_out;
    logic                       frame_done;

    modport source (output valid, output pixel_out, output frame_done, input ready);
    modport sink   (input valid, input pixel_out, input frame_done, output ready);
endinterface

interface nsup_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [nsup_pkg::REG_IDX_W-1:0] index;
    logic [nsup_pkg::REG_DAT_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/nsup_line_mem.sv =====
// Line buffer: one-write, one-read synchronous RAM, registered read data.
// No dependencies.
`default_nettype none

module nsup_line_mem #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10,
    parameter int DW    = 9
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [DW-1:0] i_wdata,
    input  wire logic          i_re,
    input  wire logic [AW-1:0] i_raddr,
    output logic      [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/nsup_out_fifo.sv =====
// Three-entry output queue decoupling the window stage from the output channel.
// Depends on nsup_pkg and nsup_if.
`default_nettype none

module nsup_out_fifo (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_push,
    input  wire nsup_pkg::t_out_word i_word,
    output logic [1:0]              o_count,
    nsup_out_if.source              o_out
);

    localparam logic [1:0] LAST = 2'd2;

    nsup_pkg::t_out_word r_buf [3];
    logic [1:0] r_wr, r_rd, r_cnt;
    logic [1:0] n_wr, n_rd, n_cnt;
    logic       pop;

    assign pop           = o_out.valid && o_out.ready;
    assign o_out.valid   = (r_cnt != 2'd0);
    assign o_out.pixel_out  = r_buf[r_rd].pixel_out;
    assign o_out.frame_done = r_buf[r_rd].frame_done;
    assign o_count       = r_cnt;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wr = (r_wr == LAST) ? 2'd0 : r_wr + 2'd1;
        end
        if (pop) begin
            n_rd = (r_rd == LAST) ? 2'd0 : r_rd + 2'd1;
        end
        if (i_push && !pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (!i_push && pop) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 2'd0;
            r_rd  <= 2'd0;
            r_cnt <= 2'd0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_buf[r_wr] <= i_word;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/neighbor_suppress_3x3_core.sv =====
// Top level: position tracking, line-buffer read-modify-write, 3x3 flag window.
// Depends on nsup_pkg, nsup_if, nsup_line_mem, nsup_out_fifo.
//
//   channel  dir  word                      handshake
//   i_in     in   opcode, pixel_in          valid/ready
//   o_out    out  pixel_out, frame_done     valid/ready
//   i_cfg    in   index, data               valid/ready (ready always high)
//
// One word per cycle while the output queue has room. A word is accepted and its
// line-buffer entry read in the same cycle; the next cycle updates the window,
// writes the entry back and queues the result. Reset (synchronous) restores the
// frame registers and the frame start; the line buffer is not cleared. A stalled
// output holds input once queued and in-flight results fill the queue.
`default_nettype none

module neighbor_suppress_3x3_core #(
    parameter int MAX_WIDTH = 1024
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    nsup_in_if.sink   i_in,
    nsup_out_if.source o_out,
    nsup_cfg_if.sink  i_cfg
);

    localparam int AW    = $clog2(MAX_WIDTH);
    localparam int ROW_W = nsup_pkg::ROW_W;
    localparam int PIX_W = nsup_pkg::PIX_W;

    typedef struct packed {
        logic [AW-1:0]    col;
        logic [PIX_W-1:0] cur;
        logic             cur_one;
        logic             out_ok;
        logic             done;
        logic [8:0]       mask;
    } t_s1;

    // configuration
    logic [nsup_pkg::CFG_W_W-1:0] r_cfg_w;
    logic [nsup_pkg::CFG_H_W-1:0] r_cfg_h;
    logic                         cfg_wr;
    logic                         cfg_hit;
    logic [AW-1:0]                w_m1;
    logic [ROW_W-1:0]             h_m1;

    // position
    logic [AW-1:0]    r_col, n_col;
    logic [ROW_W-1:0] r_row, n_row;

    // stage 0
    logic             accept, proc, draining, have;
    logic [ROW_W-1:0] pr;
    logic [AW-1:0]    pc;
    logic             has_l, has_r, has_t, has_b;
    t_s1              s0;

    // stage 1
    logic             r_s1_valid;
    t_s1              r_s1;
    logic             r_fwd;
    logic [PIX_W:0]   r_fwd_data;
    logic [PIX_W:0]   rdata, mid, wdata;
    logic [8:0]       r_win, win_next;
    logic [PIX_W-1:0] r_wcv;
    logic [2:0]       newcol;

    // output
    logic [1:0]          fifo_cnt;
    logic                push;
    nsup_pkg::t_out_word out_word;

    assign cfg_wr      = i_cfg.valid && i_cfg.ready;
    assign cfg_hit     = cfg_wr && ((i_cfg.index == nsup_pkg::REG_FRAME_WIDTH)
                                 || (i_cfg.index == nsup_pkg::REG_FRAME_HEIGHT));
    assign i_cfg.ready = 1'b1;

    always_comb begin
        if (r_cfg_w == '0) begin
            w_m1 = '0;
        end else if (32'(r_cfg_w) > 32'(MAX_WIDTH)) begin
            w_m1 = AW'(MAX_WIDTH - 1);
        end else begin
            w_m1 = AW'(32'(r_cfg_w) - 32'd1);
        end
        h_m1 = (r_cfg_h == '0) ? '0 : ROW_W'(r_cfg_h - 1'b1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w <= nsup_pkg::RST_FRAME_WIDTH;
            r_cfg_h <= nsup_pkg::RST_FRAME_HEIGHT;
        end else if (cfg_wr) begin
            if (i_cfg.index == nsup_pkg::REG_FRAME_WIDTH) begin
                r_cfg_w <= i_cfg.data[nsup_pkg::CFG_W_W-1:0];
            end else if (i_cfg.index == nsup_pkg::REG_FRAME_HEIGHT) begin
                r_cfg_h <= i_cfg.data[nsup_pkg::CFG_H_W-1:0];
            end
        end
    end

    // stage 0: position bookkeeping
    assign i_in.ready = ({1'b0, fifo_cnt} + {2'b0, r_s1_valid}) <= 3'd2;
    assign accept     = i_in.valid && i_in.ready;
    assign draining   = r_row > h_m1;
    assign proc       = draining || (i_in.opcode != nsup_pkg::OP_DRAIN);

    always_comb begin
        if (r_col != '0) begin
            have = (r_row != '0);
            pr   = r_row - ROW_W'(1);
            pc   = r_col - AW'(1);
        end else begin
            have = (r_row >= ROW_W'(2));
            pr   = r_row - ROW_W'(2);
            pc   = w_m1;
        end
        has_l = (pc != '0);
        has_r = (pc != w_m1);
        has_t = (pr != '0);
        has_b = (pr != h_m1);

        s0.col     = r_col;
        s0.cur     = draining ? '0 : i_in.pixel_in;
        s0.cur_one = !draining && (i_in.pixel_in == PIX_W'(1));
        s0.out_ok  = have && (pr <= h_m1);
        s0.done    = (pr == h_m1) && (pc == w_m1);
        s0.mask    = {has_l && has_t, has_l, has_l && has_b,
                      has_t, 1'b0, has_b,
                      has_r && has_t, has_r, has_r && has_b};

        if (s0.out_ok && s0.done) begin
            n_col = '0;
            n_row = '0;
        end else if (r_col == w_m1) begin
            n_col = '0;
            n_row = r_row + ROW_W'(1);
        end else begin
            n_col = r_col + AW'(1);
            n_row = r_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || cfg_hit) begin
            r_col <= '0;
            r_row <= '0;
        end else if (accept && proc) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    nsup_line_mem #(
        .DEPTH (MAX_WIDTH),
        .AW    (AW),
        .DW    (PIX_W + 1)
    ) u_line_mem (
        .i_clk   (i_clk),
        .i_we    (r_s1_valid),
        .i_waddr (r_s1.col),
        .i_wdata (wdata),
        .i_re    (accept && proc),
        .i_raddr (r_col),
        .o_rdata (rdata)
    );

    // stage 1: window update and write-back; {upper is-one, center value}
    assign mid      = r_fwd ? r_fwd_data : rdata;
    assign wdata    = {mid[PIX_W-1:0] == PIX_W'(1), r_s1.cur};
    assign newcol   = {mid[PIX_W], mid[PIX_W-1:0] == PIX_W'(1), r_s1.cur_one};
    assign win_next = {r_win[5:0], newcol};
    assign push     = r_s1_valid && r_s1.out_ok;

    assign out_word.pixel_out  = ((win_next & r_s1.mask) != '0) ? '0 : r_wcv;
    assign out_word.frame_done = r_s1.done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || cfg_hit) begin
            r_s1_valid <= 1'b0;
            r_fwd      <= 1'b0;
        end else begin
            r_s1_valid <= accept && proc;
            if (accept && proc) begin
                r_fwd <= r_s1_valid && (r_s1.col == r_col);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && proc) begin
            r_s1       <= s0;
            r_fwd_data <= wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || cfg_hit) begin
            r_win <= '0;
            r_wcv <= '0;
        end else if (r_s1_valid) begin
            if (r_s1.out_ok && r_s1.done) begin
                r_win <= '0;
                r_wcv <= '0;
            end else begin
                r_win <= win_next;
                r_wcv <= mid[PIX_W-1:0];
            end
        end
    end

    nsup_out_fifo u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_word  (out_word),
        .o_count (fifo_cnt),
        .o_out   (o_out)
    );

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> (fifo_cnt != 2'd3) || (o_out.valid && o_out.ready))
        else $error("output queue overflow");

    a_fwd_single_col: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_fwd) |-> (w_m1 == '0) || (r_s1.col == '0))
        else $error("forwarding away from a frame restart on a wide frame");

    a_frame_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && r_s1.done) |=> (r_win == '0) && (r_wcv == '0))
        else $error("window not cleared after end of frame");

    a_done_restarts_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && proc && s0.out_ok && s0.done && !cfg_wr) |=>
            (r_col == '0) && (r_row == '0))
        else $error("position not returned to frame start");

endmodule

`default_nettype wire

// ===== tb/sv/neighbor_suppress_3x3_core_test.sv =====
// Self-checking regression for neighbor_suppress_3x3_core: random frames with
// idling, register changes and frame aborts, checked against an in-bench predictor.
// Depends on nsup_pkg, nsup_if and the RTL of the block.
`default_nettype none

module neighbor_suppress_3x3_core_test;
    import nsup_pkg::*;

    localparam int MAX_W          = 1024;
    localparam int SETTLE_CYCLES  = 6;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int RANDOM_WORDS   = 520;
    localparam int LAST_REG_IDX   = (1 << REG_IDX_W) - 1;

    class suppression_board;
        logic [CFG_W_W-1:0] width_reg;
        logic [CFG_H_W-1:0] height_reg;
        logic [PIX_W-1:0]   row_vals [MAX_W];
        bit                 upper_one [MAX_W];
        bit [8:0]           flags;
        logic [PIX_W-1:0]   held_old;
        logic [PIX_W-1:0]   held_new;
        int unsigned        col;
        int unsigned        row;
        t_out_word          awaited_words [$];
        int                 mismatch_count;

        function void restart();
            flags    = '0;
            held_old = '0;
            held_new = '0;
            col      = 0;
            row      = 0;
        endfunction

        function void clear_all();
            width_reg  = RST_FRAME_WIDTH;
            height_reg = RST_FRAME_HEIGHT;
            foreach (row_vals[i]) begin
                row_vals[i]  = '0;
                upper_one[i] = 1'b0;
            end
            restart();
        endfunction

        function int unsigned eff_width();
            if (width_reg == 0) return 1;
            if (width_reg > MAX_W) return MAX_W;
            return width_reg;
        endfunction

        function int unsigned eff_height();
            return (height_reg == 0) ? 1 : height_reg;
        endfunction

        function int pending();
            return awaited_words.size();
        endfunction

        function void write_reg(logic [REG_IDX_W-1:0] idx, logic [REG_DAT_W-1:0] value);
            if (idx == REG_FRAME_WIDTH) begin
                width_reg = value[CFG_W_W-1:0];
                restart();
            end else if (idx == REG_FRAME_HEIGHT) begin
                height_reg = value[CFG_H_W-1:0];
                restart();
            end
        endfunction

        // returns 1 when the word takes part in the frame, 0 when ignored
        function bit take_pixel_word(t_opcode op, logic [PIX_W-1:0] pix);
            int unsigned      w;
            int unsigned      h;
            int unsigned      pr;
            int unsigned      pc;
            bit               draining;
            bit               have_out;
            bit               done;
            logic [PIX_W-1:0] cur;
            logic [PIX_W-1:0] mid;
            bit [8:0]         mask;
            t_out_word        word;
            w = eff_width();
            h = eff_height();
            draining = (row >= h);
            if (!draining && op == OP_DRAIN) return 1'b0;
            cur = draining ? '0 : pix;
            mid = row_vals[col];
            flags = {flags[5:0], upper_one[col], mid == 1, !draining && cur == 1};
            held_old = held_new;
            held_new = mid;
            upper_one[col] = (mid == 1);
            row_vals[col]  = cur;
            have_out = 1'b0;
            pr = 0;
            pc = 0;
            if (col > 0) begin
                if (row >= 1) begin
                    have_out = 1'b1;
                    pr = row - 1;
                    pc = col - 1;
                end
            end else if (row >= 2) begin
                have_out = 1'b1;
                pr = row - 2;
                pc = w - 1;
            end
            if (have_out && pr < h) begin
                mask = '0;
                if (pc > 0) begin
                    mask[7] = 1'b1;
                    mask[8] = (pr > 0);
                    mask[6] = (pr + 1 < h);
                end
                mask[5] = (pr > 0);
                mask[3] = (pr + 1 < h);
                if (pc + 1 < w) begin
                    mask[1] = 1'b1;
                    mask[2] = (pr > 0);
                    mask[0] = (pr + 1 < h);
                end
                done = (pr == h - 1) && (pc == w - 1);
                word.pixel_out  = |(flags & mask) ? '0 : held_old;
                word.frame_done = done;
                awaited_words = {awaited_words, word};
                if (done) begin
                    restart();
                    return 1'b1;
                end
            end
            col++;
            if (col >= w) begin
                col = 0;
                row++;
            end
            return 1'b1;
        endfunction

        function void match_output_word(logic [PIX_W-1:0] pix, logic done);
            t_out_word word;
            if (awaited_words.size() == 0) begin
                mismatch_count++;
                $display("%0t: unexpected word, expected none, actual pixel_out %0d %s %0b",
                         $time, pix, "frame_done", done);
                return;
            end
            word = awaited_words.pop_front();
            if (pix !== word.pixel_out) begin
                mismatch_count++;
                $display("%0t: pixel_out expected %0d actual %0d",
                         $time, word.pixel_out, pix);
            end
            if (done !== word.frame_done) begin
                mismatch_count++;
                $display("%0t: frame_done expected %0b actual %0b",
                         $time, word.frame_done, done);
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    nsup_in_if  in_ch ();
    nsup_out_if out_ch ();
    nsup_cfg_if cfg_ch ();

    neighbor_suppress_3x3_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    suppression_board board;
    int send_gap_pct;
    int stall_pct;
    int fed_words;
    int stall_left;
    int quiet_cycles;

    always #5 i_clk = ~i_clk;

    initial begin
        out_ch.ready = 1'b1;
        stall_left = 0;
        forever begin
            @(negedge i_clk);
            if (stall_left > 0) begin
                out_ch.ready = 1'b0;
                stall_left--;
            end else if (stall_pct != 0 && $urandom_range(99) < stall_pct) begin
                out_ch.ready = 1'b0;
                stall_left = $urandom_range(4, 1) - 1;
            end else begin
                out_ch.ready = 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
            board.match_output_word(out_ch.pixel_out, out_ch.frame_done);
    end

    initial begin
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
                || (cfg_ch.valid && cfg_ch.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("neighbor_suppress_3x3_core regression: fail");
        $finish;
    end

    function automatic logic [PIX_W-1:0] pick_pixel(int ones_pct);
        int r;
        r = $urandom_range(99);
        if (r < ones_pct) return 8'd1;
        case ($urandom_range(4))
            0:       return 8'd0;
            1:       return 8'd255;
            2:       return 8'd2;
            default: return PIX_W'($urandom_range(255));
        endcase
    endfunction

    task automatic send_word(t_opcode op, logic [PIX_W-1:0] pix);
        bit taken;
        if (send_gap_pct != 0 && $urandom_range(99) < send_gap_pct) begin
            in_ch.valid = 1'b0;
            repeat ($urandom_range(4, 1)) @(negedge i_clk);
        end
        in_ch.valid    = 1'b1;
        in_ch.opcode   = op;
        in_ch.pixel_in = pix;
        taken = 1'b0;
        while (!taken) begin
            @(posedge i_clk);
            taken = (in_ch.ready === 1'b1);
            if (taken) fed_words += int'(board.take_pixel_word(op, pix));
            @(negedge i_clk);
        end
    endtask

    // sender holds off until every expected word is in, then lets the pipe empty
    task automatic settle();
        in_ch.valid = 1'b0;
        while (board.pending() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [REG_DAT_W-1:0] value);
        bit taken;
        settle();
        cfg_ch.valid = 1'b1;
        cfg_ch.index = idx;
        cfg_ch.data  = value;
        taken = 1'b0;
        while (!taken) begin
            @(posedge i_clk);
            taken = (cfg_ch.ready === 1'b1);
            if (taken) board.write_reg(idx, value);
            @(negedge i_clk);
        end
        cfg_ch.valid = 1'b0;
    endtask

    task automatic set_frame(int w, int h);
        write_reg(REG_FRAME_WIDTH, REG_DAT_W'(w));
        write_reg(REG_FRAME_HEIGHT, REG_DAT_W'(h));
    endtask

    task automatic send_frame(int ones_pct, bit noisy);
        int unsigned w;
        int unsigned h;
        w = board.eff_width();
        h = board.eff_height();
        for (int unsigned i = 0; i < w * h; i++) begin
            if (noisy && $urandom_range(99) < 4)
                send_word(OP_DRAIN, PIX_W'($urandom_range(255)));
            send_word(OP_PIXEL, pick_pixel(ones_pct));
        end
        for (int unsigned i = 0; i <= w; i++) begin
            if (noisy && $urandom_range(99) < 20)
                send_word(OP_PIXEL, PIX_W'($urandom_range(255)));
            else
                send_word(OP_DRAIN, PIX_W'($urandom_range(255)));
        end
    endtask

    initial begin
        int start_words;
        int w;
        int h;
        int cut;
        bit must_cfg;
        board = new();
        board.clear_all();
        send_gap_pct   = 0;
        stall_pct      = 0;
        fed_words      = 0;
        in_ch.valid    = 1'b0;
        in_ch.opcode   = OP_PIXEL;
        in_ch.pixel_in = '0;
        cfg_ch.valid   = 1'b0;
        cfg_ch.index   = REG_FRAME_WIDTH;
        cfg_ch.data    = '0;
        i_rst_n        = 1'b0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // 3x3: early drain ignored, lone 1 kept, adjacent ones cleared,
        // pixel during drain acts as drain
        set_frame(3, 3);
        send_word(OP_DRAIN, 8'd1);
        send_word(OP_PIXEL, 8'd1);
        send_word(OP_PIXEL, 8'd0);
        send_word(OP_PIXEL, 8'd255);
        send_word(OP_PIXEL, 8'd0);
        send_word(OP_PIXEL, 8'd0);
        send_word(OP_PIXEL, 8'd2);
        send_word(OP_PIXEL, 8'd254);
        send_word(OP_PIXEL, 8'd1);
        send_word(OP_PIXEL, 8'd1);
        send_word(OP_DRAIN, 8'd0);
        send_word(OP_PIXEL, 8'd1);
        send_word(OP_DRAIN, 8'd255);
        send_word(OP_DRAIN, 8'd0);
        // 1x1 frame
        set_frame(1, 1);
        send_word(OP_PIXEL, 8'd1);
        send_word(OP_DRAIN, 8'd0);
        send_word(OP_DRAIN, 8'd0);
        // aborted 2x2, then diagonal ones
        set_frame(2, 2);
        send_word(OP_PIXEL, 8'd1);
        send_word(OP_PIXEL, 8'd1);
        write_reg(REG_FRAME_HEIGHT, REG_DAT_W'(2));
        send_word(OP_PIXEL, 8'd1);
        send_word(OP_PIXEL, 8'd0);
        send_word(OP_PIXEL, 8'd0);
        send_word(OP_PIXEL, 8'd1);
        send_frame(0, 1'b0);

        start_words = fed_words;
        must_cfg = 1'b1;
        while (fed_words - start_words < RANDOM_WORDS) begin
            case ($urandom_range(3))
                0:       send_gap_pct = 0;
                1:       send_gap_pct = 10;
                default: send_gap_pct = 30;
            endcase
            case ($urandom_range(3))
                0:       stall_pct = 0;
                1:       stall_pct = 10;
                default: stall_pct = 30;
            endcase
            if ($urandom_range(99) < 10)
                write_reg(REG_IDX_W'($urandom_range(LAST_REG_IDX, int'(REG_FRAME_HEIGHT) + 1)),
                          REG_DAT_W'($urandom_range((1 << REG_DAT_W) - 1)));
            if (must_cfg || $urandom_range(99) < 60)
                set_frame($urandom_range(12, 1), $urandom_range(6, 1));
            must_cfg = 1'b0;
            cut = $urandom_range(99);
            if (cut < 70) begin
                send_frame($urandom_range(60, 10), 1'b0);
            end else if (cut < 85) begin
                send_frame($urandom_range(60, 10), 1'b1);
            end else begin
                w = board.eff_width();
                h = board.eff_height();
                repeat ($urandom_range(w * h - 1)) send_word(OP_PIXEL, pick_pixel(40));
                must_cfg = 1'b1;
            end
            if ($urandom_range(99) < 10) settle();
        end

        // register extremes, including values outside the nominal range;
        // the large frames are cut short by the next register write
        send_gap_pct = 10;
        stall_pct    = 10;
        write_reg(REG_FRAME_WIDTH, {REG_DAT_W{1'b1}});
        write_reg(REG_FRAME_HEIGHT, REG_DAT_W'(1));
        repeat (40) send_word(OP_PIXEL, pick_pixel(30));
        set_frame(1, (1 << REG_DAT_W) - 1);
        repeat (30) send_word(OP_PIXEL, pick_pixel(40));
        // unknown register index leaves the frame running
        write_reg(REG_IDX_W'(LAST_REG_IDX), {REG_DAT_W{1'b1}});
        repeat (30) send_word(OP_PIXEL, pick_pixel(40));
        set_frame(0, 0);
        send_frame(50, 1'b1);

        // no idling on either side
        send_gap_pct = 0;
        stall_pct    = 0;
        set_frame(5, 4);
        send_frame(40, 1'b0);
        send_frame(30, 1'b1);

        settle();
        if (board.pending() != 0)
            $display("%0t: %0d expected words never arrived", $time, board.pending());
        if (board.mismatch_count == 0 && board.pending() == 0)
            $display("neighbor_suppress_3x3_core regression: pass");
        else
            $display("neighbor_suppress_3x3_core regression: fail");
        $finish;
    end

endmodule

`default_nettype wire

// ===== neighbor_suppress_3x3_core.f =====
rtl/nsup_pkg.sv
rtl/nsup_if.sv
rtl/nsup_line_mem.sv
rtl/nsup_out_fifo.sv
rtl/neighbor_suppress_3x3_core.sv
tb/sv/neighbor_suppress_3x3_core_test.sv
